@@ rtl/min_perfect_square_count_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the min perfect square count core
// Shared implication forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef MIN_PERFECT_SQUARE_COUNT_CORE_DEFINES_SVH
`define MIN_PERFECT_SQUARE_COUNT_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define MSQC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define MSQC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/msqc_pkg.sv @@
// ----------------------------------------------------------------------------
// msqc_pkg
// Widths, table depth and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package msqc_pkg;

   localparam int MAX_TARGET   = 1023;
   localparam int TARGET_W     = 10;
   localparam int TABLE_DEPTH  = MAX_TARGET + 1;
   localparam int ENTRY_W      = 11;
   localparam int ROOT_W       = 6;
   localparam int SQUARE_W     = 11;
   localparam int RESULT_W     = 3;

   // commands from controller to datapath
   typedef struct packed {
      logic load;         // latch target, reset counters
      logic init_write;   // write table[entry] = entry, advance entry
      logic pass_setup;   // entry = current square
      logic pass_step;    // read table[entry-square] and table[entry], advance
      logic next_root;    // root + 1, square = next square
      logic read_result;  // read table[target]
   } ctrl_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic entry_last;   // entry counter equals target
      logic square_fits;  // current square <= target
   } dp_status_type;

endpackage

@@ rtl/msqc_datapath.sv @@
// ----------------------------------------------------------------------------
// msqc_datapath
// Count table, entry/root counters and the pipelined min-update path.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msqc_datapath import msqc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  ctrl_cmd_type         cmd,
   input  logic [TARGET_W-1:0]  target,
   output dp_status_type        status,
   output logic [RESULT_W-1:0]  result
);

   logic [ENTRY_W-1:0]  count_table [TABLE_DEPTH];

   logic [TARGET_W-1:0] target_ff, target_in;
   logic [TARGET_W-1:0] entry_ff, entry_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [SQUARE_W-1:0] square_ff, square_in;
   logic                wr_pend_ff, wr_pend_in;
   logic [TARGET_W-1:0] wr_addr_ff;
   logic [ENTRY_W-1:0]  rd_low_ff;
   logic [ENTRY_W-1:0]  rd_cur_ff;

   logic [TARGET_W-1:0] addr_low;
   logic [TARGET_W-1:0] addr_cur;
   logic                rd_en;
   logic [ENTRY_W-1:0]  cand;
   logic                wr_en;
   logic [TARGET_W-1:0] wr_addr;
   logic [ENTRY_W-1:0]  wr_data;

   // counters and target
   always_comb begin
      target_in  = target_ff;
      entry_in   = entry_ff;
      root_in    = root_ff;
      square_in  = square_ff;
      wr_pend_in = cmd.pass_step;
      if (cmd.load) begin
         target_in = target;
         entry_in  = '0;
         root_in   = ROOT_W'(2);
         square_in = SQUARE_W'(4);
      end
      if (cmd.init_write || cmd.pass_step) begin
         entry_in = entry_ff + TARGET_W'(1);
      end
      if (cmd.pass_setup) begin
         entry_in = square_ff[TARGET_W-1:0];
      end
      if (cmd.next_root) begin
         root_in   = root_ff + ROOT_W'(1);
         // (j+1)^2 = j^2 + 2j + 1
         square_in = square_ff + SQUARE_W'({root_ff, 1'b0}) + SQUARE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff   <= '0;
         root_ff    <= '0;
         square_ff  <= '0;
         wr_pend_ff <= 1'b0;
      end else begin
         entry_ff   <= entry_in;
         root_ff    <= root_in;
         square_ff  <= square_in;
         wr_pend_ff <= wr_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff <= target_in;
      if (cmd.pass_step) begin
         wr_addr_ff <= entry_ff;
      end
   end

   // read addresses: lower entry i-s and current entry i (or the answer)
   assign addr_low = entry_ff - square_ff[TARGET_W-1:0];
   assign addr_cur = cmd.read_result ? target_ff : entry_ff;
   assign rd_en    = cmd.pass_step | cmd.read_result;

   // min update in the cycle after the read
   assign cand = rd_low_ff + ENTRY_W'(1);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = entry_ff;
      wr_data = ENTRY_W'(entry_ff);
      if (wr_pend_ff) begin
         wr_en   = cand < rd_cur_ff;
         wr_addr = wr_addr_ff;
         wr_data = cand;
      end else if (cmd.init_write) begin
         wr_en = 1'b1;
      end
   end

   // table memory: one write, two registered reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         count_table[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_low_ff <= count_table[addr_low];
         rd_cur_ff <= count_table[addr_cur];
      end
   end

   assign status.entry_last  = (entry_ff == target_ff);
   assign status.square_fits = (square_ff <= SQUARE_W'(target_ff));
   assign result             = rd_cur_ff[RESULT_W-1:0];

endmodule

@@ rtl/msqc_ctrl.sv @@
// ----------------------------------------------------------------------------
// msqc_ctrl
// Sequencer: table init, one pass per square, drain, answer read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msqc_ctrl import msqc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd,
   output logic          busy,
   output logic          rsp_valid
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_INIT  = 3'd1;
   localparam logic [2:0] ST_CHECK = 3'd2;
   localparam logic [2:0] ST_RUN   = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       valid_ff, valid_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      valid_in = 1'b0;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            cmd.init_write = 1'b1;
            if (status.entry_last) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.square_fits) begin
               cmd.pass_setup = 1'b1;
               state_in       = ST_RUN;
            end else begin
               cmd.read_result = 1'b1;
               valid_in        = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_RUN: begin
            cmd.pass_step = 1'b1;
            if (status.entry_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last write of the pass lands here
            cmd.next_root = 1'b1;
            state_in      = ST_CHECK;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

endmodule

@@ rtl/min_perfect_square_count_core.sv @@
// ----------------------------------------------------------------------------
// min_perfect_square_count_core
// Least number of perfect squares summing to a target, by table rebuild.
//
//  channel   ports                         flow
//  request   start, busy, req_target       taken when start && !busy
//  response  rsp_valid, rsp_square_count   one-cycle strobe, no stall
//
// A request updates one table entry per cycle during each pass, through the
// memory's two read ports. busy is low in the cycle the response strobes,
// so the next request may start there.
// Reset clears the sequencer; the table needs no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module min_perfect_square_count_core import msqc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [TARGET_W-1:0] req_target,
   output logic                rsp_valid,
   output logic [RESULT_W-1:0] rsp_square_count
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   msqc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   msqc_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .target (req_target),
      .status (status),
      .result (rsp_square_count)
   );

endmodule

@@ rtl/msqc_checker.sv @@
// ----------------------------------------------------------------------------
// msqc_checker
// Port-level checks on request/response sequencing, bound to the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "min_perfect_square_count_core_defines.svh"

module msqc_checker import msqc_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic [TARGET_W-1:0] req_target,
   input logic                rsp_valid,
   input logic [RESULT_W-1:0] rsp_square_count
);

   // an accepted request keeps the core busy
   `MSQC_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "request not taken")
   // one response per request: the strobe never repeats back to back
   `MSQC_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid, "double response")
   // busy ends only with a response
   `MSQC_ASSERT_NOW(a_done_resp, clock, reset, $fell(busy), rsp_valid, "busy fell silently")
   // four-square bound
   `MSQC_ASSERT_NOW(a_count_max, clock, reset, rsp_valid, rsp_square_count <= 3'd4,
      "count above four")
   // zero target: the init state, then the check state, then the strobe
   `MSQC_ASSERT_NEXT(a_zero_quick, clock, reset, start && !busy && req_target == '0,
      ##2 rsp_valid, "zero target late")

endmodule

bind min_perfect_square_count_core msqc_checker u_msqc_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_target       (req_target),
   .rsp_valid        (rsp_valid),
   .rsp_square_count (rsp_square_count)
);
